>>> hdl/ahtil_pkg.sv
package ahtil_pkg;

    // Table geometry. BUCKETS must be a power of two: the bucket index is the
    // low bits of the folded digit sum.
    localparam int BUCKETS = 1024;
    localparam int WAYS    = 4;
    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

    localparam int KEY_W   = 40;
    localparam int PWD_W   = 64;
    localparam int DIGITS  = 10;
    // 15 * (3^10 - 1) / 2 = 442860 fits in 19 bits
    localparam int HASH_W  = 20;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // weight of each nibble, least significant digit first
    localparam logic [HASH_W-1:0] POW3 [DIGITS] = '{
        20'd1, 20'd3, 20'd9, 20'd27, 20'd81,
        20'd243, 20'd729, 20'd2187, 20'd6561, 20'd19683
    };

    typedef enum logic {
        CMD_REGISTER = 1'b0,
        CMD_LOGIN    = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_NEW_OK    = 3'd0,
        ST_EXISTS    = 3'd1,
        ST_LOGIN_OK  = 3'd2,
        ST_NOT_EXIST = 3'd3,
        ST_WRONG_PW  = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        BS_CLEAR = 2'd0,
        BS_IDLE  = 2'd1,
        BS_EXEC  = 2'd2
    } t_bstate;

    typedef struct packed {
        t_cmd              cmd;
        logic [KEY_W-1:0]  key;
        logic [PWD_W-1:0]  pwd_high;
        logic [PWD_W-1:0]  pwd_low;
        logic [BKT_W-1:0]  bucket;
    } t_req;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [PWD_W-1:0]  pwd_high;
        logic [PWD_W-1:0]  pwd_low;
    } t_slot;

    typedef struct packed {
        logic [WAYS-1:0]        valid;
        t_slot [WAYS-1:0]       slot;
    } t_row;

    // h = 3*h + digit over all digits equals the sum of digit * 3^position
    function automatic logic [BKT_W-1:0] bucket_of(input logic [KEY_W-1:0] key);
        logic [HASH_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < DIGITS; i++) begin
            acc = acc + HASH_W'(key[4*i +: 4]) * POW3[i];
        end
        return acc[BKT_W-1:0];
    endfunction

endpackage

>>> hdl/ahtil_front.sv
module ahtil_front
    import ahtil_pkg::*;
(
    input  logic              i_start,
    input  logic              i_cmd,
    input  logic [KEY_W-1:0]  i_account_bcd,
    input  logic [PWD_W-1:0]  i_pwd_high,
    input  logic [PWD_W-1:0]  i_pwd_low,
    input  logic              i_q_full,
    input  logic              i_clearing,
    output logic              o_busy,
    output logic              o_push,
    output t_req              o_req
);

    assign o_busy = i_q_full | i_clearing;
    assign o_push = i_start & ~o_busy;

    // classify: tag the word with its bucket before it queues
    always_comb begin
        o_req.cmd      = t_cmd'(i_cmd);
        o_req.key      = i_account_bcd;
        o_req.pwd_high = i_pwd_high;
        o_req.pwd_low  = i_pwd_low;
        o_req.bucket   = bucket_of(i_account_bcd);
    end

endmodule

>>> hdl/ahtil_queue.sv
module ahtil_queue
    import ahtil_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_req  i_req,
    input  logic  i_pop,
    output t_req  o_head,
    output logic  o_empty,
    output logic  o_full
);

    t_req               r_entry [QDEPTH];
    logic [QPTR_W-1:0]  r_wptr;
    logic [QPTR_W-1:0]  r_rptr;
    logic [QCNT_W-1:0]  r_count;
    logic [QCNT_W-1:0]  n_count;

    assign o_head  = r_entry[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QCNT_W'(QDEPTH));

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_req;
        end
    end

endmodule

>>> hdl/ahtil_back.sv
module ahtil_back
    import ahtil_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_empty,
    input  t_req     i_head,
    output logic     o_pop,
    output logic     o_clearing,
    output logic     o_done,
    output t_status  o_status
);

    t_row               r_row_mem [BUCKETS];
    t_row               r_rd;
    t_req               r_req;
    t_bstate            r_state;
    t_bstate            n_state;
    logic [BKT_W-1:0]   r_clr_addr;
    logic               r_done;
    t_status            r_status;

    logic               w_we;
    logic [BKT_W-1:0]   w_wa;
    t_row               w_wd;
    logic [BKT_W-1:0]   w_ra;

    logic [WAYS-1:0]    w_hit_vec;
    logic [WAYS-1:0]    w_free_vec;
    logic [WAY_W-1:0]   w_hit_way;
    logic [WAY_W-1:0]   w_free_way;
    logic               w_hit;
    logic               w_free;
    logic               w_pwd_ok;
    logic               w_do_insert;
    t_status            w_status;
    t_row               w_new_row;

    // way compare on the row read last cycle
    always_comb begin
        w_hit_way  = '0;
        w_free_way = '0;
        for (int w = 0; w < WAYS; w++) begin
            w_hit_vec[w]  = r_rd.valid[w] && (r_rd.slot[w].key == r_req.key);
            w_free_vec[w] = ~r_rd.valid[w];
        end
        // lowest way wins
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (w_hit_vec[w]) begin
                w_hit_way = WAY_W'(w);
            end
            if (w_free_vec[w]) begin
                w_free_way = WAY_W'(w);
            end
        end
        w_hit    = |w_hit_vec;
        w_free   = |w_free_vec;
        w_pwd_ok = (r_rd.slot[w_hit_way].pwd_high == r_req.pwd_high) &&
                   (r_rd.slot[w_hit_way].pwd_low  == r_req.pwd_low);
    end

    always_comb begin
        w_do_insert = 1'b0;
        if (r_req.cmd == CMD_REGISTER) begin
            if (w_hit) begin
                w_status = ST_EXISTS;
            end else if (!w_free) begin
                w_status = ST_FULL;
            end else begin
                w_status    = ST_NEW_OK;
                w_do_insert = 1'b1;
            end
        end else begin
            if (!w_hit) begin
                w_status = ST_NOT_EXIST;
            end else if (w_pwd_ok) begin
                w_status = ST_LOGIN_OK;
            end else begin
                w_status = ST_WRONG_PW;
            end
        end
    end

    always_comb begin
        w_new_row                         = r_rd;
        w_new_row.valid[w_free_way]       = 1'b1;
        w_new_row.slot[w_free_way].key      = r_req.key;
        w_new_row.slot[w_free_way].pwd_high = r_req.pwd_high;
        w_new_row.slot[w_free_way].pwd_low  = r_req.pwd_low;
    end

    // next state
    always_comb begin
        case (r_state)
            BS_CLEAR: begin
                n_state = (r_clr_addr == BKT_W'(BUCKETS - 1)) ? BS_IDLE : BS_CLEAR;
            end
            BS_IDLE: begin
                n_state = i_empty ? BS_IDLE : BS_EXEC;
            end
            BS_EXEC: begin
                n_state = BS_IDLE;
            end
            default: begin
                n_state = BS_CLEAR;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_pop = 1'b0;
        w_we  = 1'b0;
        w_wa  = r_req.bucket;
        w_wd  = w_new_row;
        w_ra  = i_head.bucket;
        case (r_state)
            BS_CLEAR: begin
                w_we = 1'b1;
                w_wa = r_clr_addr;
                w_wd = '0;
            end
            BS_IDLE: begin
                o_pop = ~i_empty;
            end
            BS_EXEC: begin
                w_we = w_do_insert;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BS_CLEAR;
            r_clr_addr <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == BS_EXEC);
            if (r_state == BS_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BS_EXEC) begin
            r_status <= w_status;
        end
        if (o_pop) begin
            r_req <= i_head;
        end
    end

    // bucket row store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_row_mem[w_wa] <= w_wd;
        end
        r_rd <= r_row_mem[w_ra];
    end

    assign o_clearing = (r_state == BS_CLEAR);
    assign o_done     = r_done;
    assign o_status   = r_status;

endmodule

>>> hdl/account_hash_table_insert_lookup_core.sv
// o_done pulses after an accepted word passes the queue, the row read in IDLE, the compare in EXEC
// and the done register. The back end takes a new word only after the row read and write back of the last.
// Reset: synchronous, active low; afterwards busy stays high while the valid bits of all BUCKETS (1024)
// bucket rows are cleared, one row per cycle.
// The receiver cannot stall: each status is shown for one cycle with o_done.
module account_hash_table_insert_lookup_core
    import ahtil_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_cmd,
    input  logic [KEY_W-1:0]  i_account_bcd,
    input  logic [PWD_W-1:0]  i_pwd_high,
    input  logic [PWD_W-1:0]  i_pwd_low,
    output logic              o_done,
    output logic [2:0]        o_status
);

    // front end -> queue
    logic     w_push;
    t_req     w_req;
    // queue -> back end
    t_req     w_head;
    logic     w_q_empty;
    logic     w_q_full;
    logic     w_pop;
    // back end status
    logic     w_clearing;
    t_status  w_status;

    // Front end: hashes the account number into a bucket and queues the word.
    // It only refuses a word when the queue is full or the table is clearing.
    ahtil_front u_front (
        .i_start       (start),
        .i_cmd         (i_cmd),
        .i_account_bcd (i_account_bcd),
        .i_pwd_high    (i_pwd_high),
        .i_pwd_low     (i_pwd_low),
        .i_q_full      (w_q_full),
        .i_clearing    (w_clearing),
        .o_busy        (busy),
        .o_push        (w_push),
        .o_req         (w_req)
    );

    // Two-entry queue decouples the hash stage from the table access.
    ahtil_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_req   (w_req),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    // Back end: reads the whole bucket row (all ways), compares in parallel,
    // writes the row back on a successful insert and registers the status.
    ahtil_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (w_q_empty),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_clearing (w_clearing),
        .o_done     (o_done),
        .o_status   (w_status)
    );

    assign o_status = w_status;

    // one word in the back end at a time, so strobes never touch
    a_done_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("status strobes on consecutive cycles");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status <= ST_FULL))
        else $error("undefined status code");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> (busy && !w_pop && !w_push))
        else $error("table traffic during clearing pass");

endmodule
